// ----- rtl/lcd_window_pixel_byte_generator_unit_defines.svh -----
// Assertion macros shared by the RTL files.
`ifndef LCD_WINDOW_PIXEL_BYTE_GENERATOR_UNIT_DEFINES_SVH
`define LCD_WINDOW_PIXEL_BYTE_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked in reset-free operation.
`define LWPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define LWPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LWPB_ASSERT(lbl, prop, msg)
`define LWPB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/lwpb_pkg.sv -----
package lwpb_pkg;

  // Command codes on in_command.
  localparam logic [1:0] CMD_WINDOW = 2'd0;
  localparam logic [1:0] CMD_PIXEL  = 2'd1;
  localparam logic [1:0] CMD_GLYPH  = 2'd2;

  // Controller opcodes.
  localparam logic [7:0] OP_COLUMN_SET  = 8'h2A;
  localparam logic [7:0] OP_ROW_SET     = 8'h2B;
  localparam logic [7:0] OP_MEMORY_WRITE = 8'h2C;

  // Byte position counter within one item.
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] WIN_LAST   = 4'd10;
  localparam logic [IDX_W-1:0] PIX_LAST   = 4'd1;
  localparam logic [IDX_W-1:0] GLYPH_LAST = 4'd15;

  // Descriptor queue between front and back (depth must be a power of two).
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_WINDOW,
    KIND_PIXEL,
    KIND_GLYPH
  } kind_t;

  // One classified item. Window: w0 sx, w1 ex, w2 sy, w3 ey.
  // Pixel: w0 colour. Glyph: w0 fore, w1 back, bits font row.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic [7:0]  bits;
  } desc_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/lwpb_front.sv -----
module lwpb_front (
  input  logic             push,
  output logic             full,
  input  logic [1:0]       in_command,
  input  logic [15:0]      in_start_x,
  input  logic [15:0]      in_start_y,
  input  logic [15:0]      in_win_width,
  input  logic [15:0]      in_win_height,
  input  logic [15:0]      in_fore_color,
  input  logic [15:0]      in_back_color,
  input  logic [7:0]       in_glyph_bits,
  input  lwpb_pkg::q_stat_t q_stat,
  output logic             q_push,
  output lwpb_pkg::desc_t  q_desc
);
  import lwpb_pkg::*;

  logic        accept;
  logic        known;
  logic [15:0] end_x;
  logic [15:0] end_y;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;
  assign q_push = accept && known;

  // End addresses wrap modulo 2^16.
  assign end_x = in_start_x + in_win_width - 16'd1;
  assign end_y = in_start_y + in_win_height - 16'd1;

  always_comb begin
    known       = 1'b1;
    q_desc.kind = KIND_PIXEL;
    q_desc.w0   = in_fore_color;
    q_desc.w1   = in_back_color;
    q_desc.w2   = in_start_y;
    q_desc.w3   = end_y;
    q_desc.bits = in_glyph_bits;
    case (in_command)
      CMD_WINDOW: begin
        q_desc.kind = KIND_WINDOW;
        q_desc.w0   = in_start_x;
        q_desc.w1   = end_x;
      end
      CMD_PIXEL: begin
        q_desc.kind = KIND_PIXEL;
      end
      CMD_GLYPH: begin
        q_desc.kind = KIND_GLYPH;
      end
      default: begin
        // unused code: item is swallowed, no bytes
        known = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/lwpb_queue.sv -----
`include "lcd_window_pixel_byte_generator_unit_defines.svh"

module lwpb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  lwpb_pkg::desc_t   q_din,
  input  logic              q_pop,
  output lwpb_pkg::desc_t   q_head,
  output lwpb_pkg::q_stat_t q_stat
);
  import lwpb_pkg::*;

  desc_t           ent_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_head       = ent_r[rd_ptr_r];

  assign do_push = q_push && !q_stat.full;
  assign do_pop  = q_pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= q_din;
    end
  end

  `LWPB_ASSERT(a_q_cnt_range, (cnt_r <= Q_CW'(Q_DEPTH)), "queue count over depth")
  `LWPB_ASSERT(a_q_ptr_empty, (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r), "empty queue, ptrs differ")

endmodule

// ----- rtl/lwpb_back.sv -----
`include "lcd_window_pixel_byte_generator_unit_defines.svh"

module lwpb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lwpb_pkg::q_stat_t q_stat,
  input  lwpb_pkg::desc_t   q_head,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              out_is_data,
  output logic              out_last
);
  import lwpb_pkg::*;

  desc_t            cur_r, cur_nxt;
  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             vld_r, vld_nxt;
  logic [7:0]       byte_r;
  logic             data_r;
  logic             last_r;

  logic             can_load;
  logic             emit;
  logic             take;
  logic [7:0]       gen_byte;
  logic             gen_data;
  logic             gen_last;
  logic [15:0]      glyph_col;

  assign empty       = !vld_r;
  assign out_byte    = byte_r;
  assign out_is_data = data_r;
  assign out_last    = last_r;

  // Output register frees up when empty or being popped this edge.
  assign can_load = !vld_r || pop;
  assign emit     = busy_r && can_load;
  assign take     = (!busy_r || (emit && gen_last)) && !q_stat.empty;
  assign q_pop    = take;

  // glyph: two bytes per pixel, pixel index is idx/2, bit 0 first
  assign glyph_col = cur_r.bits[idx_r[IDX_W-1:1]] ? cur_r.w0 : cur_r.w1;

  always_comb begin
    gen_byte = 8'h00;
    gen_data = 1'b1;
    gen_last = 1'b0;
    case (cur_r.kind)
      KIND_WINDOW: begin
        gen_last = (idx_r == WIN_LAST);
        case (idx_r)
          4'd0: begin
            gen_byte = OP_COLUMN_SET;
            gen_data = 1'b0;
          end
          4'd1:    gen_byte = cur_r.w0[15:8];
          4'd2:    gen_byte = cur_r.w0[7:0];
          4'd3:    gen_byte = cur_r.w1[15:8];
          4'd4:    gen_byte = cur_r.w1[7:0];
          4'd5: begin
            gen_byte = OP_ROW_SET;
            gen_data = 1'b0;
          end
          4'd6:    gen_byte = cur_r.w2[15:8];
          4'd7:    gen_byte = cur_r.w2[7:0];
          4'd8:    gen_byte = cur_r.w3[15:8];
          4'd9:    gen_byte = cur_r.w3[7:0];
          default: begin
            gen_byte = OP_MEMORY_WRITE;
            gen_data = 1'b0;
          end
        endcase
      end
      KIND_PIXEL: begin
        gen_last = (idx_r == PIX_LAST);
        gen_byte = idx_r[0] ? cur_r.w0[7:0] : cur_r.w0[15:8];
      end
      KIND_GLYPH: begin
        gen_last = (idx_r == GLYPH_LAST);
        gen_byte = idx_r[0] ? glyph_col[7:0] : glyph_col[15:8];
      end
      default: begin
        gen_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    cur_nxt  = take ? q_head : cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (take) begin
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (emit) begin
      idx_nxt  = idx_r + 1'b1;
      busy_nxt = !gen_last;
    end
    vld_nxt = emit ? 1'b1 : (pop ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      byte_r <= gen_byte;
      data_r <= gen_data;
      last_r <= gen_last;
    end
  end

  `LWPB_ASSERT(a_idx_win, (busy_r && cur_r.kind == KIND_WINDOW) |-> (idx_r <= WIN_LAST), "win idx")
  `LWPB_ASSERT(a_idx_pix, (busy_r && cur_r.kind == KIND_PIXEL) |-> (idx_r <= PIX_LAST), "pix idx")
  `LWPB_ASSERT(a_take_idle, take |-> (!busy_r || (emit && gen_last)), "taken mid-item")
  `LWPB_ASSERT_ALWAYS(a_reset_clears, (!rst_n) |=> (!busy_r && !vld_r), "reset left busy")

endmodule

// ----- rtl/lcd_window_pixel_byte_generator_unit.sv -----
// Channel   Handshake     Payload
// input     push / full   in_command, in_start_x .. in_glyph_bits (eight fields)
// result    empty / pop   out_byte, out_is_data, out_last
//
// One result byte per cycle while pop is held and items wait; an item gives 11 bytes (window),
// 2 (pixel) or 16 (glyph row), set by the back-end byte sequencer.
// The 2-deep descriptor queue takes an item per cycle while it has room; full rises
// only when two items wait behind the one in work. Command code 3 is taken, dropped.
// rst_n is synchronous, active low; clears queue pointers, sequencer, output valid.
// A stalled pop holds the output byte and backs up the sequencer.
module lcd_window_pixel_byte_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_start_x,
  input  logic [15:0] in_start_y,
  input  logic [15:0] in_win_width,
  input  logic [15:0] in_win_height,
  input  logic [15:0] in_fore_color,
  input  logic [15:0] in_back_color,
  input  logic [7:0]  in_glyph_bits,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last
);
  import lwpb_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  desc_t   q_din;
  desc_t   q_head;

  // Front: classify the item and work out window end addresses.
  lwpb_front u_front (
    .push          (push),
    .full          (full),
    .in_command    (in_command),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_win_width  (in_win_width),
    .in_win_height (in_win_height),
    .in_fore_color (in_fore_color),
    .in_back_color (in_back_color),
    .in_glyph_bits (in_glyph_bits),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_desc        (q_din)
  );

  // Descriptor queue decouples the two sides.
  lwpb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_din  (q_din),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // Back: steps through the bytes of one descriptor into the output register.
  lwpb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .out_is_data (out_is_data),
    .out_last    (out_last)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import lwpb_pkg::*;

  // Code 3 is not used by the block: accepted and dropped.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Idle modes, one per phase of the run.
  localparam logic [1:0] MODE_FLAT      = 2'd0;  // nobody idles
  localparam logic [1:0] MODE_SRC_IDLE  = 2'd1;  // sender idle 88 of 100
  localparam logic [1:0] MODE_SINK_IDLE = 2'd2;  // receiver stalls 88 of 100
  localparam logic [1:0] MODE_BOTH      = 2'd3;  // both at 17 of 100

  localparam int RANDOM_ITEMS = 330;
  localparam int WATCHDOG     = 3000;  // cycles with no item moving either way
  localparam int TAIL_CYCLES  = 40;    // a glyph row is 16 bytes, leave margin

  // One drawing item as the sender holds it. flush marks a pause point:
  // the sender waits there until every expected byte has come out.
  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] fg;
    logic [15:0] bg;
    logic [7:0]  bits;
    logic        flush;
    logic [1:0]  mode;
  } draw_item_t;

  // One byte toward the display controller.
  typedef struct {
    logic [7:0] val;
    logic       is_data;
    logic       last;
  } lcd_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_command = '0;
  logic [15:0] in_start_x = '0;
  logic [15:0] in_start_y = '0;
  logic [15:0] in_win_width = '0;
  logic [15:0] in_win_height = '0;
  logic [15:0] in_fore_color = '0;
  logic [15:0] in_back_color = '0;
  logic [7:0]  in_glyph_bits = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_data;
  logic        out_last;

  draw_item_t  draw_q[$];   // items waiting to be offered
  lcd_byte_t   byte_q[$];   // bytes the display should see, oldest first
  logic [1:0]  cur_mode = MODE_FLAT;

  int unsigned n_window, n_pixel, n_glyph, n_dropped, n_bytes, n_errors;
  int unsigned stall_run;

  lcd_window_pixel_byte_generator_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_command   (in_command),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_win_width (in_win_width),
    .in_win_height(in_win_height),
    .in_fore_color(in_fore_color),
    .in_back_color(in_back_color),
    .in_glyph_bits(in_glyph_bits),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_is_data  (out_is_data),
    .out_last     (out_last)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Byte stream predictor
  // ---------------------------------------------------------------------------
  task automatic emit_byte(input logic [7:0] b, input logic data);
    lcd_byte_t e;
    e.val     = b;
    e.is_data = data;
    e.last    = 1'b0;
    byte_q.push_back(e);
  endtask

  // Words go out high byte first.
  task automatic emit_word(input logic [15:0] wd);
    emit_byte(wd[15:8], 1'b1);
    emit_byte(wd[7:0], 1'b1);
  endtask

  task automatic predict_lcd_bytes(input draw_item_t it);
    logic [15:0] end_x;
    logic [15:0] end_y;
    lcd_byte_t   tail;
    // end address wraps at 16 bits, so a zero size gives start minus one
    end_x = it.sx + it.w - 16'd1;
    end_y = it.sy + it.h - 16'd1;
    case (it.cmd)
      CMD_WINDOW: begin
        emit_byte(OP_COLUMN_SET, 1'b0);
        emit_word(it.sx);
        emit_word(end_x);
        emit_byte(OP_ROW_SET, 1'b0);
        emit_word(it.sy);
        emit_word(end_y);
        emit_byte(OP_MEMORY_WRITE, 1'b0);
      end
      CMD_PIXEL: emit_word(it.fg);
      CMD_GLYPH: begin
        // bit 0 is the leftmost pixel
        for (int i = 0; i < 8; i++)
          emit_word(it.bits[i] ? it.fg : it.bg);
      end
      default: return;  // unused code: nothing comes out
    endcase
    tail = byte_q.pop_back();
    tail.last = 1'b1;
    byte_q.push_back(tail);
  endtask

  // ---------------------------------------------------------------------------
  // Sender. An item moves on an edge with push high and full low; the
  // prediction is made right there from the values that were on the ports.
  // push gets at most one nonblocking write per edge, none while a push waits on full.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sender
    draw_item_t cur;
    draw_item_t nxt;
    logic       offer;
    int unsigned idle_pct;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        cur.cmd  = in_command;
        cur.sx   = in_start_x;
        cur.sy   = in_start_y;
        cur.w    = in_win_width;
        cur.h    = in_win_height;
        cur.fg   = in_fore_color;
        cur.bg   = in_back_color;
        cur.bits = in_glyph_bits;
        predict_lcd_bytes(cur);
        case (cur.cmd)
          CMD_WINDOW: n_window++;
          CMD_PIXEL:  n_pixel++;
          CMD_GLYPH:  n_glyph++;
          default:    n_dropped++;
        endcase
      end
      offer = 1'b0;
      if (draw_q.size() != 0) begin
        if (draw_q[0].flush) begin
          // pause point: hold off until the output side has caught up
          if (byte_q.size() == 0) begin
            nxt = draw_q.pop_front();
            cur_mode = nxt.mode;
          end
        end else begin
          case (draw_q[0].mode)
            MODE_SRC_IDLE: idle_pct = 88;
            MODE_BOTH:     idle_pct = 17;
            default:       idle_pct = 0;
          endcase
          if ($urandom_range(99) >= idle_pct) begin
            nxt = draw_q.pop_front();
            cur_mode = nxt.mode;
            offer = 1'b1;
            in_command    <= nxt.cmd;
            in_start_x    <= nxt.sx;
            in_start_y    <= nxt.sy;
            in_win_width  <= nxt.w;
            in_win_height <= nxt.h;
            in_fore_color <= nxt.fg;
            in_back_color <= nxt.bg;
            in_glyph_bits <= nxt.bits;
          end
        end
      end
      push <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker: a byte moves on an edge with pop high and empty low.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    lcd_byte_t   want;
    int unsigned stall_pct;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_bytes++;
        if (byte_q.size() == 0) begin
          $error("byte 0x%02h came out with nothing expected", out_byte);
          n_errors++;
        end else begin
          want = byte_q.pop_front();
          if (out_byte !== want.val) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.val, out_byte);
            n_errors++;
          end
          if (out_is_data !== want.is_data) begin
            $error("out_is_data: expected %0d, got %0d", want.is_data, out_is_data);
            n_errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_last);
            n_errors++;
          end
        end
      end
      case (cur_mode)
        MODE_SINK_IDLE: stall_pct = 88;
        MODE_BOTH:      stall_pct = 17;
        default:        stall_pct = 0;
      endcase
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long with nothing moving on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty))
      stall_run <= 0;
    else
      stall_run <= stall_run + 1;
    if (stall_run >= WATCHDOG) begin
      $display("timeout: nothing moved for %0d cycles", WATCHDOG);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic draw_item_t make_item(input logic [1:0] cmd, input logic [15:0] sx,
                                           input logic [15:0] sy, input logic [15:0] w,
                                           input logic [15:0] h, input logic [15:0] fg,
                                           input logic [15:0] bg, input logic [7:0] bits,
                                           input logic [1:0] mode);
    draw_item_t it;
    it.cmd   = cmd;
    it.sx    = sx;
    it.sy    = sy;
    it.w     = w;
    it.h     = h;
    it.fg    = fg;
    it.bg    = bg;
    it.bits  = bits;
    it.flush = 1'b0;
    it.mode  = mode;
    return it;
  endfunction

  // Mostly full-range values, now and then a corner value.
  function automatic logic [15:0] pick16();
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_flush(input logic [1:0] mode);
    draw_item_t it;
    it = make_item(CMD_WINDOW, '0, '0, '0, '0, '0, '0, '0, mode);
    it.flush = 1'b1;
    draw_q.push_back(it);
  endtask

  initial begin
    int unsigned n_rand;
    int unsigned pick;
    logic [1:0]  cmd;
    logic [1:0]  mode;
    logic [1:0]  prev_mode;

    // Directed: window corners (zero sizes wrap to start minus one)
    draw_q.push_back(make_item(CMD_WINDOW, 16'd0, 16'd0, 16'd240, 16'd320, '0, '0, '0,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_WINDOW, 16'd10, 16'd20, 16'd0, 16'd0, '1, '1, '1,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_WINDOW, 16'd0, 16'd0, 16'd0, 16'd0, '0, '0, '0,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, '0,
                               '0, MODE_FLAT));
    draw_q.push_back(make_item(CMD_WINDOW, 16'hFFFF, 16'h8000, 16'd1, 16'd1, '0, '0, '0,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_WINDOW, 16'h1234, 16'hABCD, 16'h8000, 16'h7FFF,
                               16'h5A5A, 16'hA5A5, 8'h3C, MODE_FLAT));
    // pixels, plus stray values on fields that a pixel ignores
    draw_q.push_back(make_item(CMD_PIXEL, '0, '0, '0, '0, 16'h0000, '0, '0, MODE_FLAT));
    draw_q.push_back(make_item(CMD_PIXEL, '1, '1, '1, '1, 16'hFFFF, '1, '1, MODE_FLAT));
    draw_q.push_back(make_item(CMD_PIXEL, '0, '0, '0, '0, 16'h8000, '0, '0, MODE_FLAT));
    draw_q.push_back(make_item(CMD_PIXEL, '0, '0, '0, '0, 16'h00FF, '0, '0, MODE_FLAT));
    draw_q.push_back(make_item(CMD_PIXEL, '0, '0, '0, '0, 16'hFF00, '0, '0, MODE_FLAT));
    // glyph rows: blank, solid, single ends, checker
    draw_q.push_back(make_item(CMD_GLYPH, '0, '0, '0, '0, 16'hFFFF, 16'h0000, 8'h00,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_GLYPH, '0, '0, '0, '0, 16'hF800, 16'h001F, 8'hFF,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_GLYPH, '0, '0, '0, '0, 16'h07E0, 16'hFFFF, 8'h01,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_GLYPH, '1, '1, '1, '1, 16'h0000, 16'hFFFF, 8'h80,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_GLYPH, '0, '0, '0, '0, 16'h1234, 16'hFEDC, 8'hA5,
                               MODE_FLAT));
    draw_q.push_back(make_item(CMD_GLYPH, '0, '0, '0, '0, 16'h8001, 16'h7FFE, 8'h5A,
                               MODE_FLAT));
    // unused code dropped between two producing items
    draw_q.push_back(make_item(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1, MODE_FLAT));
    draw_q.push_back(make_item(CMD_PIXEL, '0, '0, '0, '0, 16'hC3C3, '0, '0, MODE_FLAT));
    draw_q.push_back(make_item(CMD_UNUSED, '0, '0, '0, '0, '0, '0, '0, MODE_FLAT));
    add_flush(MODE_FLAT);

    // Random part in four idle phases; drop codes do not count toward the total.
    n_rand = 0;
    prev_mode = MODE_FLAT;
    while (n_rand < RANDOM_ITEMS) begin
      mode = 2'(n_rand * 4 / RANDOM_ITEMS);
      if (mode != prev_mode) add_flush(mode);
      // extra pause in the middle of the sender-idle phase
      if (mode == MODE_SRC_IDLE && n_rand == RANDOM_ITEMS * 3 / 8) add_flush(mode);
      prev_mode = mode;
      pick = $urandom_range(99);
      if (pick < 30)      cmd = CMD_WINDOW;
      else if (pick < 60) cmd = CMD_PIXEL;
      else if (pick < 92) cmd = CMD_GLYPH;
      else                cmd = CMD_UNUSED;
      draw_q.push_back(make_item(cmd, pick16(), pick16(), pick16(), pick16(), pick16(),
                                 pick16(), 8'($urandom), mode));
      if (cmd != CMD_UNUSED) n_rand++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // All offered and taken, then every byte out, then a quiet tail.
    while (draw_q.size() != 0 || push) @(posedge clk);
    while (byte_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (byte_q.size() != 0) begin
      $error("%0d expected bytes never came out", byte_q.size());
      n_errors++;
    end

    $display("covered %0d windows, %0d pixels, %0d glyph rows, %0d dropped codes",
             n_window, n_pixel, n_glyph, n_dropped);
    $display("checked %0d bytes under steady flow, sender gaps, receiver stalls and both",
             n_bytes);
    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
